// ===== sv/swmm_pkg.sv =====
// Shared types for the sliding-window min/max block.
// No dependencies; used by sliding_window_min_max_top and swmm_extreme_scan.
`timescale 1ns / 1ps

package swmm_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Control that travels with one word of read data into the scanner
    typedef struct packed {
        logic valid;   // read data is live this cycle
        logic first;   // word belongs to slot zero, restarts the search
    } scan_ctl_t;

endpackage

// ===== sv/swmm_if.sv =====
// Stream interfaces for the sliding-window min/max block: sample in, extremes out.
// No dependencies.
`timescale 1ns / 1ps

interface swmm_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swmm_out_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_min;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_min, output window_max, input ready);
    modport sink   (input valid, input window_min, input window_max, output ready);
endinterface

// ===== sv/sliding_window_min_max_top.sv =====
// Top level of the sliding-window min/max block: sequencer, tracked extremes, result register.
// Depends on swmm_pkg, swmm_if, swmm_window_ram and swmm_extreme_scan.
`timescale 1ns / 1ps

// Usage
//   samples : one signed sample per item (valid/ready, taken when both high).
//   results : one item per sample, carrying the minimum and maximum of the last
//             WINDOW_DEPTH samples including the new one.
//   Each sample is written into a circular window held in a single-port-read RAM.
//   The value and slot of the current minimum and maximum sit in registers, so
//   most items need no RAM read: they go straight to the final step, which
//   loads the output register and returns to idle for the next sample.
//   When the write lands on the slot of the minimum or maximum, the whole window
//   is rescanned, one RAM read per cycle; one pass serves both extremes. Such an
//   item goes through the scan, drain and final steps before its result is
//   registered; the single read port of the window RAM sets the scan's length.
//   One item is worked on at a time; samples.ready is high while idle, also when
//   a finished result still waits in the output register. If results is stalled,
//   the next item waits in its final step until the register frees up.
//   Reset: the window reads as all zero (slots not yet written since reset are
//   masked to zero by a wrap flag, so there is no clearing pass), write slot,
//   min slot and max slot are zero, and no result is pending.

module sliding_window_min_max_top #(
    parameter int WINDOW_DEPTH = 256,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    swmm_in_if.sink    samples,
    swmm_out_if.source results
);

    localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(WINDOW_DEPTH - 1);

    swmm_pkg::state_t state_reg, state_next;

    // window position and tracked extremes
    logic [ADDR_W-1:0]              wp_reg, wp_next;
    logic                           wrapped_reg, wrapped_next;
    logic [ADDR_W-1:0]              min_pos_reg, min_pos_next;
    logic [ADDR_W-1:0]              max_pos_reg, max_pos_next;
    logic signed [SAMPLE_WIDTH-1:0] min_val_reg, min_val_next;
    logic signed [SAMPLE_WIDTH-1:0] max_val_reg, max_val_next;

    // current item
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           need_min_reg;
    logic                           need_max_reg;

    // rescan address and read pipeline stage
    logic [ADDR_W-1:0]              scan_addr_reg, scan_addr_next;
    logic                           rd_valid_reg;
    logic                           rd_first_reg;
    logic                           rd_written_reg;
    logic [ADDR_W-1:0]              rd_idx_reg;
    logic                           rd_en;

    // result register
    logic                           out_valid_reg, out_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] out_min_reg, out_min_next;
    logic signed [SAMPLE_WIDTH-1:0] out_max_reg, out_max_next;

    logic                           in_accept;
    logic signed [SAMPLE_WIDTH-1:0] ram_q;
    logic signed [SAMPLE_WIDTH-1:0] scan_data;
    swmm_pkg::scan_ctl_t            scan_ctl;
    logic signed [SAMPLE_WIDTH-1:0] scan_min_val, scan_max_val;
    logic [ADDR_W-1:0]              scan_min_idx, scan_max_idx;

    // extremes after any rescan, before the new sample is weighed
    logic signed [SAMPLE_WIDTH-1:0] cur_min_val, cur_max_val;
    logic [ADDR_W-1:0]              cur_min_pos, cur_max_pos;

    assign in_accept     = samples.valid && samples.ready;
    assign samples.ready = (state_reg == swmm_pkg::ST_IDLE);

    assign results.valid      = out_valid_reg;
    assign results.window_min = out_min_reg;
    assign results.window_max = out_max_reg;

    swmm_window_ram #(
        .DEPTH  (WINDOW_DEPTH),
        .WIDTH  (SAMPLE_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (wp_reg),
        .wr_data (samples.sample),
        .rd_en   (rd_en),
        .rd_addr (scan_addr_reg),
        .rd_data (ram_q)
    );

    // slots never written since reset still hold the reset zero
    assign scan_data      = rd_written_reg ? ram_q : '0;
    assign scan_ctl.valid = rd_valid_reg;
    assign scan_ctl.first = rd_first_reg;

    swmm_extreme_scan #(
        .WIDTH  (SAMPLE_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_scan (
        .clk     (clk),
        .ctl     (scan_ctl),
        .idx     (rd_idx_reg),
        .data    (scan_data),
        .min_val (scan_min_val),
        .min_idx (scan_min_idx),
        .max_val (scan_max_val),
        .max_idx (scan_max_idx)
    );

    assign cur_min_val = need_min_reg ? scan_min_val : min_val_reg;
    assign cur_min_pos = need_min_reg ? scan_min_idx : min_pos_reg;
    assign cur_max_val = need_max_reg ? scan_max_val : max_val_reg;
    assign cur_max_pos = need_max_reg ? scan_max_idx : max_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swmm_pkg::ST_IDLE;
            wp_reg        <= '0;
            wrapped_reg   <= 1'b0;
            min_pos_reg   <= '0;
            max_pos_reg   <= '0;
            min_val_reg   <= '0;
            max_val_reg   <= '0;
            scan_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            wrapped_reg   <= wrapped_next;
            min_pos_reg   <= min_pos_next;
            max_pos_reg   <= max_pos_next;
            min_val_reg   <= min_val_next;
            max_val_reg   <= max_val_next;
            scan_addr_reg <= scan_addr_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg   <= samples.sample;
            need_min_reg <= (wp_reg == min_pos_reg);
            need_max_reg <= (wp_reg == max_pos_reg);
        end
        rd_first_reg   <= (scan_addr_reg == '0);
        rd_idx_reg     <= scan_addr_reg;
        rd_written_reg <= wrapped_reg || (scan_addr_reg <= wp_reg);
        out_min_reg    <= out_min_next;
        out_max_reg    <= out_max_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        wrapped_next   = wrapped_reg;
        min_pos_next   = min_pos_reg;
        max_pos_next   = max_pos_reg;
        min_val_next   = min_val_reg;
        max_val_next   = max_val_reg;
        scan_addr_next = scan_addr_reg;
        rd_en          = 1'b0;
        out_valid_next = out_valid_reg && !results.ready;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;

        unique case (state_reg)
            swmm_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if ((wp_reg == min_pos_reg) || (wp_reg == max_pos_reg))
                    begin
                        state_next = swmm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = swmm_pkg::ST_FINISH;
                    end
                end
            end
            swmm_pkg::ST_SCAN:
            begin
                rd_en = 1'b1;
                if (scan_addr_reg == LAST_SLOT)
                begin
                    scan_addr_next = '0;
                    state_next     = swmm_pkg::ST_DRAIN;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            swmm_pkg::ST_DRAIN:
            begin
                // last read word enters the scanner
                state_next = swmm_pkg::ST_FINISH;
            end
            swmm_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    min_pos_next = cur_min_pos;
                    min_val_next = cur_min_val;
                    max_pos_next = cur_max_pos;
                    max_val_next = cur_max_val;
                    if (sample_reg < cur_min_val)
                    begin
                        min_pos_next = wp_reg;
                        min_val_next = sample_reg;
                    end
                    else if (sample_reg > cur_max_val)
                    begin
                        max_pos_next = wp_reg;
                        max_val_next = sample_reg;
                    end
                    out_valid_next = 1'b1;
                    out_min_next   = min_val_next;
                    out_max_next   = max_val_next;
                    if (wp_reg == LAST_SLOT)
                    begin
                        wp_next      = '0;
                        wrapped_next = 1'b1;
                    end
                    else
                    begin
                        wp_next = wp_reg + 1'b1;
                    end
                    state_next = swmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swmm_pkg::ST_IDLE;
            end
        endcase
    end

    // tracked extremes never cross
    a_extremes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        min_val_reg <= max_val_reg)
        else $error("tracked minimum above tracked maximum");

    a_result_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_min_reg <= out_max_reg))
        else $error("result minimum above result maximum");

    // scan address rests at zero outside a rescan
    a_scan_addr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != swmm_pkg::ST_SCAN) |-> (scan_addr_reg == '0))
        else $error("scan address moved outside a rescan");

    a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == swmm_pkg::ST_SCAN || state_reg == swmm_pkg::ST_DRAIN))
        else $error("read data live outside a rescan");

    // an item that evicts no extreme skips the rescan
    a_no_scan_when_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (wp_reg != min_pos_reg) && (wp_reg != max_pos_reg))
        |=> (state_reg == swmm_pkg::ST_FINISH))
        else $error("rescan started without an evicted extreme");

endmodule

// ===== sv/swmm_window_ram.sv =====
// Window sample memory: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module swmm_window_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 8
) (
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [ADDR_W-1:0]       wr_addr,
    input  logic signed [WIDTH-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [ADDR_W-1:0]       rd_addr,
    output logic signed [WIDTH-1:0] rd_data
);

    logic signed [WIDTH-1:0] mem [DEPTH];
    logic signed [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/swmm_extreme_scan.sv =====
// Running min/max search over a stream of window words, lowest index wins ties.
// Depends on swmm_pkg (scan_ctl_t).
`timescale 1ns / 1ps

module swmm_extreme_scan #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 8
) (
    input  logic                    clk,
    input  swmm_pkg::scan_ctl_t     ctl,
    input  logic [ADDR_W-1:0]       idx,
    input  logic signed [WIDTH-1:0] data,
    output logic signed [WIDTH-1:0] min_val,
    output logic [ADDR_W-1:0]       min_idx,
    output logic signed [WIDTH-1:0] max_val,
    output logic [ADDR_W-1:0]       max_idx
);

    logic signed [WIDTH-1:0] min_val_reg;
    logic [ADDR_W-1:0]       min_idx_reg;
    logic signed [WIDTH-1:0] max_val_reg;
    logic [ADDR_W-1:0]       max_idx_reg;

    // strict compares keep the earlier slot on a tie
    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            if (ctl.first || (data < min_val_reg))
            begin
                min_val_reg <= data;
                min_idx_reg <= idx;
            end
            if (ctl.first || (data > max_val_reg))
            begin
                max_val_reg <= data;
                max_idx_reg <= idx;
            end
        end
    end

    assign min_val = min_val_reg;
    assign min_idx = min_idx_reg;
    assign max_val = max_val_reg;
    assign max_idx = max_idx_reg;

endmodule

// ===== test/sliding_window_min_max_top_tb.sv =====
// Testbench for sliding_window_min_max_top: drives signed samples and checks every
// window minimum/maximum item against a cycle-free model of the tracked extremes.
// Depends on swmm_if.sv (stream interfaces) and the block's RTL.
`timescale 1ns / 1ps

module sliding_window_min_max_top_tb;

    localparam int WINDOW_DEPTH  = 256;
    localparam int SAMPLE_WIDTH  = 16;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1700;
    // Slowest correct run: every item forces a full rescan of the window
    // plus random sender gaps and receiver stalls; this is several times that.
    localparam int LIMIT_CYCLES  = 2_500_000;
    // Quiet time at the end: longer than one full rescan, so a stray item would show up.
    localparam int SETTLE_CYCLES = WINDOW_DEPTH + 50;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct packed {
        sample_t window_min;
        sample_t window_max;
    } extremes_t;

    // Tracks the window, the min/max slots, and the extremes each sample must produce.
    class window_extrema_tracker;
        sample_t   window [WINDOW_DEPTH];
        int        wr_slot;
        int        lo_slot;
        int        hi_slot;
        extremes_t expected_extremes [$];
        int        mismatches;
        int        checked;
        int        rescans;

        function new();
            foreach (window[i])
                window[i] = '0;
            wr_slot    = 0;
            lo_slot    = 0;
            hi_slot    = 0;
            mismatches = 0;
            checked    = 0;
            rescans    = 0;
        endfunction

        function void insert_sample(sample_t s);
            extremes_t e;
            int        slot;
            slot         = wr_slot;
            window[slot] = s;
            // Evicted minimum: rescan, strict compare so the lowest slot wins a tie
            if (slot == lo_slot)
            begin
                lo_slot = 0;
                for (int i = 1; i < WINDOW_DEPTH; i++)
                    if (window[i] < window[lo_slot])
                        lo_slot = i;
                rescans++;
            end
            if (slot == hi_slot)
            begin
                hi_slot = 0;
                for (int i = 1; i < WINDOW_DEPTH; i++)
                    if (window[i] > window[hi_slot])
                        hi_slot = i;
                rescans++;
            end
            if (s < window[lo_slot])
                lo_slot = slot;
            else if (s > window[hi_slot])
                hi_slot = slot;
            wr_slot = (slot + 1 == WINDOW_DEPTH) ? 0 : slot + 1;
            e.window_min = window[lo_slot];
            e.window_max = window[hi_slot];
            expected_extremes.push_back(e);
        endfunction

        function void check_extremes(sample_t got_min, sample_t got_max);
            extremes_t want;
            if (expected_extremes.size() == 0)
            begin
                $display("%0t: unexpected result item, min %0d max %0d",
                         $time, got_min, got_max);
                mismatches++;
                return;
            end
            want = expected_extremes.pop_front();
            checked++;
            if (got_min !== want.window_min)
            begin
                $display("%0t: window_min expected %0d, got %0d",
                         $time, want.window_min, got_min);
                mismatches++;
            end
            if (got_max !== want.window_max)
            begin
                $display("%0t: window_max expected %0d, got %0d",
                         $time, want.window_max, got_max);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_extremes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   cycles;
    int   items_sent;

    window_extrema_tracker tracker;

    // Extremes of the range, ties on both ends, alternating bit patterns, zeros
    sample_t directed_samples [14] = '{5, 0, -32768, 32767, -1, 1, -32768, 32767,
                                       21845, -21846, 0, 0, 7, -7};

    swmm_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) samples_if ();
    swmm_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) results_if ();

    sliding_window_min_max_top #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if),
        .results (results_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Run limit: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("[sliding_window_min_max_top] ERROR");
            $finish;
        end
    end

    // Result side: check on the handshake, then pick ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
            tracker.check_extremes(results_if.window_min, results_if.window_max);
        results_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // One sample: optional idle cycles, then hold valid until the block takes it.
    task automatic send_sample(sample_t s);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid  <= 1'b1;
        samples_if.sample <= s;
        do
            @(posedge clk);
        while (!samples_if.ready);
        tracker.insert_sample(s);
        items_sent++;
    endtask

    // Sender holds off until every outstanding result has arrived.
    task automatic wait_for_results();
        samples_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Random segments. Ramps keep evicting the oldest extreme and force rescans,
    // narrow bands and plateaus build ties, plateaus of up to 300 samples can give a
    // window of equal values, and plain noise covers every bit of the field.
    task automatic send_random_segments(int count);
        int      sent;
        int      mode;
        int      seg_len;
        int      base;
        int      step;
        sample_t v;
        sent = 0;
        while (sent < count)
        begin
            mode = $urandom_range(0, 9);
            base = int'($urandom_range(0, 65535)) - 32768;
            step = $urandom_range(1, 300);
            case (mode)
                0, 1, 2: seg_len = $urandom_range(1, 60);
                3, 4, 5, 6: seg_len = $urandom_range(50, 320);
                7: seg_len = $urandom_range(20, 120);
                8: seg_len = $urandom_range(10, 60);
                default: seg_len = $urandom_range(250, 300);
            endcase
            for (int k = 0; k < seg_len && sent < count; k++)
            begin
                case (mode)
                    0, 1, 2: v = sample_t'($urandom_range(0, 65535));
                    3, 4: v = sample_t'(base + k * step);
                    5, 6: v = sample_t'(base - k * step);
                    7: v = sample_t'(base + int'($urandom_range(0, 6)) - 3);
                    8:
                    begin
                        case ($urandom_range(0, 3))
                            0: v = sample_t'(-32768);
                            1: v = sample_t'(32767);
                            2: v = sample_t'(0);
                            default: v = sample_t'(-1);
                        endcase
                    end
                    default: v = sample_t'(base);
                endcase
                send_sample(v);
                sent++;
            end
        end
    endtask

    initial
    begin
        tracker           = new();
        cycles            = 0;
        items_sent        = 0;
        tx_idle_pct       = 27;
        rx_idle_pct       = 76;
        rst_n             = 1'b0;
        samples_if.valid  = 1'b0;
        samples_if.sample = '0;
        results_if.ready  = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the first sample evicts both extremes of the zeroed window
        foreach (directed_samples[i])
            send_sample(directed_samples[i]);

        // Phase 1: sender idles sometimes, receiver stalls often
        send_random_segments(RANDOM_ITEMS / 3);
        wait_for_results();

        // Phase 2: roles swapped
        tx_idle_pct = 76;
        rx_idle_pct = 27;
        send_random_segments(RANDOM_ITEMS / 3);
        wait_for_results();

        // Phase 3: back to back, no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_segments(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d samples, checked %0d result items, %0d extreme rescans predicted.",
                 items_sent, tracker.checked, tracker.rescans);
        $display("Covered ramps, ties, plateaus over a full window and random noise.");
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("[sliding_window_min_max_top] OK");
        else
            $display("[sliding_window_min_max_top] ERROR");
        $finish;
    end

endmodule
